[hdl/gnms_pkg.sv]
// Shared types, codes and constants for the graph non-maximum suppression unit.
package gnms_pkg;

    localparam int MAX_VALUES_DEF     = 64;
    localparam int MAX_NEIGHBOURS_DEF = 8;

    localparam int SCORE_W    = 32;
    localparam int POS_W      = 6;
    localparam int CNT_W      = 4;
    localparam int VCNT_W     = 7;
    localparam int RATIO_W    = 16;
    localparam int ACT_W      = 2;
    localparam int FRAC_SHIFT = 15;
    localparam int CMP_W      = SCORE_W + RATIO_W + 1;

    localparam logic [RATIO_W-1:0] RATIO_RESET = 16'd16384;

    typedef enum logic [ACT_W-1:0] {
        ACT_VALUE     = 2'd0,
        ACT_NEIGHBOUR = 2'd1,
        ACT_RUN       = 2'd2
    } action_t;

    typedef struct packed {
        logic score_we;
        logic cnt_we;
        logic nb_we;
        logic drop_we;
    } mem_wr_t;

endpackage

[hdl/gnms_mem.sv]
// Score, neighbour, neighbour-count and drop-flag memories with registered reads.
module gnms_mem
    import gnms_pkg::*;
#(
    parameter int MAX_VALUES     = MAX_VALUES_DEF,
    parameter int MAX_NEIGHBOURS = MAX_NEIGHBOURS_DEF,
    localparam int VAL_AW = (MAX_VALUES > 1) ? $clog2(MAX_VALUES) : 1,
    localparam int NB_AW  = (MAX_VALUES * MAX_NEIGHBOURS > 1) ?
                            $clog2(MAX_VALUES * MAX_NEIGHBOURS) : 1
)
(
    input  logic                       clk,
    input  mem_wr_t                    wr,
    input  logic [VAL_AW-1:0]          val_waddr,
    input  logic signed [SCORE_W-1:0]  score_wdata,
    input  logic [CNT_W-1:0]           cnt_wdata,
    input  logic                       drop_wdata,
    input  logic [NB_AW-1:0]           nb_waddr,
    input  logic [POS_W-1:0]           nb_wdata,
    input  logic [VAL_AW-1:0]          val_raddr,
    input  logic [VAL_AW-1:0]          score_raddr_b,
    input  logic [NB_AW-1:0]           nb_raddr,
    output logic signed [SCORE_W-1:0]  score_a,
    output logic signed [SCORE_W-1:0]  score_b,
    output logic [CNT_W-1:0]           cnt_rd,
    output logic [POS_W-1:0]           nb_rd,
    output logic                       drop_rd
);

    logic signed [SCORE_W-1:0] score_mem [MAX_VALUES];
    logic [CNT_W-1:0]          cnt_mem   [MAX_VALUES];
    logic                      drop_mem  [MAX_VALUES];
    logic [POS_W-1:0]          nb_mem    [MAX_VALUES * MAX_NEIGHBOURS];

    always_ff @(posedge clk)
    begin
        if (wr.score_we)
        begin
            score_mem[val_waddr] <= score_wdata;
        end
        if (wr.cnt_we)
        begin
            cnt_mem[val_waddr] <= cnt_wdata;
        end
        if (wr.drop_we)
        begin
            drop_mem[val_waddr] <= drop_wdata;
        end
        if (wr.nb_we)
        begin
            nb_mem[nb_waddr] <= nb_wdata;
        end
        score_a <= score_mem[val_raddr];
        score_b <= score_mem[score_raddr_b];
        cnt_rd  <= cnt_mem[val_raddr];
        drop_rd <= drop_mem[val_raddr];
        nb_rd   <= nb_mem[nb_raddr];
    end

endmodule

[hdl/gnms_cmp.sv]
// Shared signed magnitude comparator used by the maximum and neighbour passes of a run.
module gnms_cmp
    import gnms_pkg::*;
(
    input  logic signed [CMP_W-1:0] op_a,
    input  logic signed [CMP_W-1:0] op_b,
    output logic                    lt
);

    assign lt = (op_a < op_b);

endmodule

[hdl/graph_non_maximum_suppression_unit.sv]
// Top level: load sequencer, run sequencer and result register of the suppression unit.
// Load beats (append value, append neighbour) are taken while idle; busy stays low.
// A run keeps busy high while it walks the registered-read memories in a maximum pass, a
// neighbour pass and an emit pass, the first two using the one shared comparator; an empty
// set goes straight to the final beat.
// One-cycle result strobes on result_valid, the last just after busy falls; no stall input.
// Reset (rst_n low, asynchronous) empties the set, clears overflow and sets ratio to 0.5.
module graph_non_maximum_suppression_unit
    import gnms_pkg::*;
#(
    parameter int MAX_VALUES     = MAX_VALUES_DEF,
    parameter int MAX_NEIGHBOURS = MAX_NEIGHBOURS_DEF
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [ACT_W-1:0]           action,
    input  logic signed [SCORE_W-1:0]  score,
    input  logic [POS_W-1:0]           neighbour_index,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [RATIO_W-1:0]         cfg_data,
    output logic                       result_valid,
    output logic [POS_W-1:0]           position,
    output logic signed [SCORE_W-1:0]  kept_score,
    output logic                       last,
    output logic                       empty_res,
    output logic                       overflow
);

    localparam int VAL_AW = (MAX_VALUES > 1) ? $clog2(MAX_VALUES) : 1;
    localparam int NB_AW  = (MAX_VALUES * MAX_NEIGHBOURS > 1) ?
                            $clog2(MAX_VALUES * MAX_NEIGHBOURS) : 1;

    // Run sequencer. Every read is issued in one state and used in the next,
    // since the memories register their read data.
    typedef enum logic [3:0] {
        S_IDLE,
        S_MAX_RD,   // read score i
        S_MAX_CMP,  // fold score i into the running maximum
        S_LIMIT,    // multiply maximum by ratio
        S_NB_RD,    // read score i and its neighbour count
        S_NB_HDR,   // threshold test, issue first neighbour read
        S_NB_ADR,   // issue read of neighbour j
        S_NB_IDX,   // range-check neighbour index, issue its score read
        S_NB_CMP,   // compare score i with neighbour score
        S_NB_WR,    // store the drop flag of value i
        S_EM_RD,    // read score i and its drop flag
        S_EM_CHK,   // hand on the held survivor, hold this one
        S_EM_END    // final beat: held survivor or empty marker
    } state_t;

    state_t                    state_reg, state_next;
    logic [VCNT_W-1:0]         value_count_reg, value_count_next;
    logic [CNT_W-1:0]          last_cnt_reg, last_cnt_next;
    logic                      overflow_seen_reg, overflow_seen_next;
    logic [RATIO_W-1:0]        ratio_reg, ratio_next;
    logic [VAL_AW-1:0]         i_reg, i_next;
    logic [CNT_W-1:0]          j_reg, j_next;
    logic [CNT_W-1:0]          cnt_reg, cnt_next;
    logic signed [SCORE_W-1:0] max_reg, max_next;
    logic signed [CMP_W-1:0]   limit_reg, limit_next;
    logic signed [SCORE_W-1:0] s_i_reg, s_i_next;
    logic                      drop_reg, drop_next;
    logic                      ovf_reg, ovf_next;
    logic                      have_pend_reg, have_pend_next;
    logic [POS_W-1:0]          pend_pos_reg, pend_pos_next;
    logic signed [SCORE_W-1:0] pend_score_reg, pend_score_next;
    logic                      result_valid_reg, result_valid_next;
    logic [POS_W-1:0]          position_reg, position_next;
    logic signed [SCORE_W-1:0] kept_score_reg, kept_score_next;
    logic                      last_reg, last_next;
    logic                      empty_res_reg, empty_res_next;
    logic                      overflow_reg, overflow_next;

    mem_wr_t                   mem_wr;
    logic [VAL_AW-1:0]         val_waddr;
    logic [CNT_W-1:0]          cnt_wdata;
    logic [NB_AW-1:0]          nb_waddr;
    logic [NB_AW-1:0]          nb_raddr;
    logic signed [SCORE_W-1:0] score_a;
    logic signed [SCORE_W-1:0] score_b;
    logic [CNT_W-1:0]          cnt_rd;
    logic [POS_W-1:0]          nb_rd;
    logic                      drop_rd;

    logic signed [CMP_W-1:0]   cmp_a;
    logic signed [CMP_W-1:0]   cmp_b;
    logic                      cmp_lt;
    logic signed [CMP_W-1:0]   prod;

    logic                      take;
    logic [VCNT_W-1:0]         lastv;
    logic                      last_i;
    logic                      last_j;

    assign busy         = (state_reg != S_IDLE);
    assign cfg_ready    = ~busy;
    assign result_valid = result_valid_reg;
    assign position     = position_reg;
    assign kept_score   = kept_score_reg;
    assign last         = last_reg;
    assign empty_res    = empty_res_reg;
    assign overflow     = overflow_reg;

    assign take   = start && !busy;
    assign lastv  = value_count_reg - VCNT_W'(1);
    assign last_i = ((VCNT_W'(i_reg) + VCNT_W'(1)) == value_count_reg);
    assign last_j = ((j_reg + CNT_W'(1)) == cnt_reg);

    // Neighbour list of value i lives in a fixed slot of MAX_NEIGHBOURS entries.
    assign nb_raddr = NB_AW'(i_reg) * NB_AW'(MAX_NEIGHBOURS) + NB_AW'(j_reg);
    assign nb_waddr = NB_AW'(lastv[VAL_AW-1:0]) * NB_AW'(MAX_NEIGHBOURS)
                      + NB_AW'(last_cnt_reg);

    // Threshold limit: maximum times unsigned Q1.15 ratio, kept at full width.
    assign prod = max_reg * $signed({1'b0, ratio_reg});

    gnms_mem #(
        .MAX_VALUES     (MAX_VALUES),
        .MAX_NEIGHBOURS (MAX_NEIGHBOURS)
    ) u_mem (
        .clk           (clk),
        .wr            (mem_wr),
        .val_waddr     (val_waddr),
        .score_wdata   (score),
        .cnt_wdata     (cnt_wdata),
        .drop_wdata    (drop_reg),
        .nb_waddr      (nb_waddr),
        .nb_wdata      (neighbour_index),
        .val_raddr     (i_reg),
        .score_raddr_b (nb_rd[VAL_AW-1:0]),
        .nb_raddr      (nb_raddr),
        .score_a       (score_a),
        .score_b       (score_b),
        .cnt_rd        (cnt_rd),
        .nb_rd         (nb_rd),
        .drop_rd       (drop_rd)
    );

    gnms_cmp u_cmp (
        .op_a (cmp_a),
        .op_b (cmp_b),
        .lt   (cmp_lt)
    );

    // Feed the shared comparator according to the pass in progress.
    always_comb
    begin
        cmp_a = '0;
        cmp_b = '0;
        case (state_reg)
            S_MAX_CMP:
            begin
                // lt means the new score beats the running maximum
                cmp_a = CMP_W'(max_reg);
                cmp_b = CMP_W'(score_a);
            end
            S_NB_HDR:
            begin
                // score * 32768 against max * ratio, exact
                cmp_a = CMP_W'($signed({score_a, {FRAC_SHIFT{1'b0}}}));
                cmp_b = limit_reg;
            end
            S_NB_CMP:
            begin
                cmp_a = CMP_W'(s_i_reg);
                cmp_b = CMP_W'(score_b);
            end
            default:
            begin
                cmp_a = '0;
                cmp_b = '0;
            end
        endcase
    end

    always_comb
    begin
        state_next         = state_reg;
        value_count_next   = value_count_reg;
        last_cnt_next      = last_cnt_reg;
        overflow_seen_next = overflow_seen_reg;
        ratio_next         = ratio_reg;
        i_next             = i_reg;
        j_next             = j_reg;
        cnt_next           = cnt_reg;
        max_next           = max_reg;
        limit_next         = limit_reg;
        s_i_next           = s_i_reg;
        drop_next          = drop_reg;
        ovf_next           = ovf_reg;
        have_pend_next     = have_pend_reg;
        pend_pos_next      = pend_pos_reg;
        pend_score_next    = pend_score_reg;
        result_valid_next  = 1'b0;
        position_next      = position_reg;
        kept_score_next    = kept_score_reg;
        last_next          = last_reg;
        empty_res_next     = empty_res_reg;
        overflow_next      = overflow_reg;
        mem_wr             = '0;
        val_waddr          = i_reg;
        cnt_wdata          = '0;

        if (cfg_valid && cfg_ready)
        begin
            ratio_next = cfg_data;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (take)
                begin
                    case (action)
                        ACT_VALUE:
                        begin
                            if (value_count_reg < VCNT_W'(MAX_VALUES))
                            begin
                                mem_wr.score_we  = 1'b1;
                                mem_wr.cnt_we    = 1'b1;
                                val_waddr        = value_count_reg[VAL_AW-1:0];
                                cnt_wdata        = '0;
                                value_count_next = value_count_reg + VCNT_W'(1);
                                last_cnt_next    = '0;
                            end
                            else
                            begin
                                overflow_seen_next = 1'b1;
                            end
                        end
                        ACT_NEIGHBOUR:
                        begin
                            if (value_count_reg == '0 ||
                                last_cnt_reg >= CNT_W'(MAX_NEIGHBOURS))
                            begin
                                overflow_seen_next = 1'b1;
                            end
                            else
                            begin
                                mem_wr.nb_we  = 1'b1;
                                mem_wr.cnt_we = 1'b1;
                                val_waddr     = lastv[VAL_AW-1:0];
                                cnt_wdata     = last_cnt_reg + CNT_W'(1);
                                last_cnt_next = last_cnt_reg + CNT_W'(1);
                            end
                        end
                        ACT_RUN:
                        begin
                            ovf_next       = overflow_seen_reg;
                            have_pend_next = 1'b0;
                            i_next         = '0;
                            j_next         = '0;
                            state_next     = (value_count_reg == '0) ? S_EM_END : S_MAX_RD;
                        end
                        default:
                        begin
                            // unused action code: drop the beat
                        end
                    endcase
                end
            end
            S_MAX_RD:
            begin
                state_next = S_MAX_CMP;
            end
            S_MAX_CMP:
            begin
                if (i_reg == '0 || cmp_lt)
                begin
                    max_next = score_a;
                end
                if (last_i)
                begin
                    state_next = S_LIMIT;
                end
                else
                begin
                    i_next     = i_reg + VAL_AW'(1);
                    state_next = S_MAX_RD;
                end
            end
            S_LIMIT:
            begin
                limit_next = prod;
                i_next     = '0;
                j_next     = '0;
                state_next = S_NB_RD;
            end
            S_NB_RD:
            begin
                state_next = S_NB_HDR;
            end
            S_NB_HDR:
            begin
                s_i_next   = score_a;
                cnt_next   = cnt_rd;
                drop_next  = cmp_lt;
                // first neighbour read is already under way (j is zero)
                state_next = (cnt_rd == '0) ? S_NB_WR : S_NB_IDX;
            end
            S_NB_ADR:
            begin
                state_next = S_NB_IDX;
            end
            S_NB_IDX:
            begin
                if ({1'b0, nb_rd} >= value_count_reg)
                begin
                    // index out of range: skip it, flag the run
                    ovf_next = 1'b1;
                    if (last_j)
                    begin
                        state_next = S_NB_WR;
                    end
                    else
                    begin
                        j_next     = j_reg + CNT_W'(1);
                        state_next = S_NB_ADR;
                    end
                end
                else
                begin
                    state_next = S_NB_CMP;
                end
            end
            S_NB_CMP:
            begin
                if (cmp_lt)
                begin
                    drop_next = 1'b1;
                end
                if (last_j)
                begin
                    state_next = S_NB_WR;
                end
                else
                begin
                    j_next     = j_reg + CNT_W'(1);
                    state_next = S_NB_ADR;
                end
            end
            S_NB_WR:
            begin
                mem_wr.drop_we = 1'b1;
                val_waddr      = i_reg;
                j_next         = '0;
                if (last_i)
                begin
                    i_next     = '0;
                    state_next = S_EM_RD;
                end
                else
                begin
                    i_next     = i_reg + VAL_AW'(1);
                    state_next = S_NB_RD;
                end
            end
            S_EM_RD:
            begin
                state_next = S_EM_CHK;
            end
            S_EM_CHK:
            begin
                if (!drop_rd)
                begin
                    // a later survivor exists, so the held one is not last
                    if (have_pend_reg)
                    begin
                        result_valid_next = 1'b1;
                        position_next     = pend_pos_reg;
                        kept_score_next   = pend_score_reg;
                        last_next         = 1'b0;
                        empty_res_next    = 1'b0;
                        overflow_next     = ovf_reg;
                    end
                    have_pend_next  = 1'b1;
                    pend_pos_next   = POS_W'(i_reg);
                    pend_score_next = score_a;
                end
                if (last_i)
                begin
                    state_next = S_EM_END;
                end
                else
                begin
                    i_next     = i_reg + VAL_AW'(1);
                    state_next = S_EM_RD;
                end
            end
            S_EM_END:
            begin
                result_valid_next = 1'b1;
                last_next         = 1'b1;
                overflow_next     = ovf_reg;
                if (have_pend_reg)
                begin
                    position_next   = pend_pos_reg;
                    kept_score_next = pend_score_reg;
                    empty_res_next  = 1'b0;
                end
                else
                begin
                    position_next   = '0;
                    kept_score_next = '0;
                    empty_res_next  = 1'b1;
                end
                // start a fresh set
                value_count_next   = '0;
                last_cnt_next      = '0;
                overflow_seen_next = 1'b0;
                state_next         = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            value_count_reg   <= '0;
            last_cnt_reg      <= '0;
            overflow_seen_reg <= 1'b0;
            ratio_reg         <= RATIO_RESET;
            i_reg             <= '0;
            j_reg             <= '0;
            cnt_reg           <= '0;
            max_reg           <= '0;
            limit_reg         <= '0;
            s_i_reg           <= '0;
            drop_reg          <= 1'b0;
            ovf_reg           <= 1'b0;
            have_pend_reg     <= 1'b0;
            pend_pos_reg      <= '0;
            pend_score_reg    <= '0;
            result_valid_reg  <= 1'b0;
            position_reg      <= '0;
            kept_score_reg    <= '0;
            last_reg          <= 1'b0;
            empty_res_reg     <= 1'b0;
            overflow_reg      <= 1'b0;
        end
        else
        begin
            state_reg         <= state_next;
            value_count_reg   <= value_count_next;
            last_cnt_reg      <= last_cnt_next;
            overflow_seen_reg <= overflow_seen_next;
            ratio_reg         <= ratio_next;
            i_reg             <= i_next;
            j_reg             <= j_next;
            cnt_reg           <= cnt_next;
            max_reg           <= max_next;
            limit_reg         <= limit_next;
            s_i_reg           <= s_i_next;
            drop_reg          <= drop_next;
            ovf_reg           <= ovf_next;
            have_pend_reg     <= have_pend_next;
            pend_pos_reg      <= pend_pos_next;
            pend_score_reg    <= pend_score_next;
            result_valid_reg  <= result_valid_next;
            position_reg      <= position_next;
            kept_score_reg    <= kept_score_next;
            last_reg          <= last_next;
            empty_res_reg     <= empty_res_next;
            overflow_reg      <= overflow_next;
        end
    end

endmodule

[hdl/gnms_checker.sv]
// Port-level checker for the suppression unit and its bind to the top level.
module gnms_checker
    import gnms_pkg::*;
(
    input logic                      clk,
    input logic                      rst_n,
    input logic                      start,
    input logic                      busy,
    input logic [ACT_W-1:0]          action,
    input logic                      result_valid,
    input logic [POS_W-1:0]          position,
    input logic signed [SCORE_W-1:0] kept_score,
    input logic                      last,
    input logic                      empty_res
);

    // An empty marker closes its run and carries no survivor.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && empty_res |-> last && position == '0 && kept_score == '0)
    else $error("empty result beat malformed");

    // A run beat makes the unit busy on the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && action == ACT_RUN |=> busy)
    else $error("run beat did not start a run");

    // Results come only out of a run in progress.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(busy))
    else $error("result beat outside a run");

    // The last beat of a run is never followed at once by another.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && last |=> !result_valid)
    else $error("result beat straight after the last one");

endmodule

bind graph_non_maximum_suppression_unit gnms_checker u_gnms_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .action       (action),
    .result_valid (result_valid),
    .position     (position),
    .kept_score   (kept_score),
    .last         (last),
    .empty_res    (empty_res)
);
